>>> rtl/bitplane_run_length_gamma_encoder_defines.svh
// Assertion macros shared by the encoder modules.
`ifndef BITPLANE_RUN_LENGTH_GAMMA_ENCODER_DEFINES_SVH
`define BITPLANE_RUN_LENGTH_GAMMA_ENCODER_DEFINES_SVH

// Property that must hold whenever the condition holds, in the same cycle.
`define BRLG_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Property that must hold in the cycle after the condition.
`define BRLG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/brlg_pkg.sv
// Shared constants and the command type passed from the classifier to the packer.
package brlg_pkg;

	localparam int RUN_W   = 18;
	localparam int TOTAL_W = 18;
	localparam int BYTE_W  = 8;
	localparam int MODE_W  = 2;

	localparam logic [MODE_W-1:0] MODE_RAW = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RLE = 2'd1;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// A segment holds an optional single bit followed by one gamma code.
	localparam int SEG_W  = 2 * RUN_W;
	localparam int LEN_W  = $clog2(SEG_W + 1);
	localparam int ACC_W  = SEG_W + BYTE_W;
	localparam int FILL_W = $clog2(ACC_W + 1);
	localparam int K_W    = $clog2(RUN_W + 1);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Bits of a segment are left aligned: the first bit to send is the MSB.
	typedef struct packed {
		logic [SEG_W-1:0]   seg1;
		logic [LEN_W-1:0]   len1;
		logic [SEG_W-1:0]   seg2;
		logic [LEN_W-1:0]   len2;
		logic               fin;
		logic [TOTAL_W-1:0] total;
	} brlg_cmd_t;

endpackage

>>> rtl/brlg_ifs.sv
// Valid/ready channel interfaces for pixel input and coded byte output.
interface brlg_pixel_if;
	import brlg_pkg::*;

	logic valid;
	logic ready;
	logic pixel_value;
	logic final_pixel;

	modport source(output valid, output pixel_value, output final_pixel, input ready);
	modport sink(input valid, input pixel_value, input final_pixel, output ready);
endinterface

interface brlg_code_if;
	import brlg_pkg::*;

	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  data_byte;
	logic               byte_valid;
	logic               stream_end;
	logic [TOTAL_W-1:0] encoded_bits;

	modport source(output valid, output data_byte, output byte_valid, output stream_end,
		output encoded_bits, input ready);
	modport sink(input valid, input data_byte, input byte_valid, input stream_end,
		input encoded_bits, output ready);
endinterface

>>> rtl/brlg_front.sv
// Front end: run tracking, gamma code shaping and bit counting per pixel.
`include "bitplane_run_length_gamma_encoder_defines.svh"

module brlg_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [brlg_pkg::MODE_W-1:0]   cfg_wdata,
	brlg_pixel_if.sink                    pix_in,
	output logic                          push_valid,
	input  logic                          push_ready,
	output brlg_pkg::brlg_cmd_t           push_cmd
);
	import brlg_pkg::*;

	// Number of significant bits of a run length.
	function automatic logic [K_W-1:0] sig_bits(input logic [RUN_W-1:0] n);
		logic [K_W-1:0] k;
		k = '0;
		for (int i = 0; i < RUN_W; i++) begin
			if (n[i]) begin
				k = K_W'(i + 1);
			end
		end
		return k;
	endfunction

	// Gamma code of n, left aligned: k-1 zeros, then the k bits of n.
	function automatic logic [SEG_W-1:0] gamma_field(input logic [RUN_W-1:0] n,
		input logic [K_W-1:0] k);
		logic [LEN_W-1:0] sh;
		sh = LEN_W'(SEG_W) - (LEN_W'(k) << 1) + LEN_W'(1);
		return {{(SEG_W - RUN_W){1'b0}}, n} << sh;
	endfunction

	function automatic logic [LEN_W-1:0] gamma_len(input logic [K_W-1:0] k);
		return (k == '0) ? '0 : (LEN_W'(k) << 1) - LEN_W'(1);
	endfunction

	logic [MODE_W-1:0]  mode_q;
	logic               run_pixel_q;
	logic [RUN_W-1:0]   run_len_q;
	logic               first_q;
	logic [TOTAL_W-1:0] bit_total_q;

	logic               accept;
	logic               is_raw, is_rle, coded;
	logic               pix, fin;
	logic               close_run;
	logic [RUN_W-1:0]   run_len_d;
	logic [RUN_W-1:0]   n_a, n_b;
	logic [K_W-1:0]     k_a, k_b;
	logic [LEN_W-1:0]   glen_a, glen_b;
	logic [SEG_W-1:0]   g_a, g_b;
	logic               single_cnt, single_pack;
	logic [LEN_W:0]     added;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] total_d;

	assign pix    = pix_in.pixel_value;
	assign fin    = pix_in.final_pixel;
	assign accept = pix_in.valid && push_ready;

	assign pix_in.ready = push_ready;
	assign push_valid   = pix_in.valid;

	assign is_raw = (mode_q == MODE_RAW);
	assign is_rle = (mode_q == MODE_RLE);
	assign coded  = !is_raw;

	always_comb begin
		close_run = 1'b0;
		if (first_q) begin
			run_len_d = RUN_W'(1);
		end else if (pix == run_pixel_q) begin
			run_len_d = (run_len_q == '1) ? run_len_q : run_len_q + RUN_W'(1);
		end else begin
			run_len_d = RUN_W'(1);
			close_run = 1'b1;
		end
	end

	assign n_a    = (coded && close_run) ? run_len_q : '0;
	assign n_b    = (coded && fin) ? run_len_d : '0;
	assign k_a    = sig_bits(n_a);
	assign k_b    = sig_bits(n_b);
	assign glen_a = gamma_len(k_a);
	assign glen_b = gamma_len(k_b);
	assign g_a    = is_rle ? gamma_field(n_a, k_a) : '0;
	assign g_b    = is_rle ? gamma_field(n_b, k_b) : '0;

	// In raw mode every pixel is one bit; in coded modes only the first pixel is.
	assign single_cnt  = is_raw || first_q;
	assign single_pack = is_raw || (first_q && is_rle);

	assign added   = (LEN_W + 1)'(single_cnt) + (LEN_W + 1)'(glen_a) + (LEN_W + 1)'(glen_b);
	assign sum     = {1'b0, bit_total_q} + (TOTAL_W + 1)'(added);
	assign total_d = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

	always_comb begin
		push_cmd.seg1  = single_pack ? {pix, g_a[SEG_W-1:1]} : g_a;
		push_cmd.len1  = LEN_W'(single_pack) + (is_rle ? glen_a : '0);
		push_cmd.seg2  = g_b;
		push_cmd.len2  = is_rle ? glen_b : '0;
		push_cmd.fin   = fin;
		push_cmd.total = total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RLE;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_pixel_q <= 1'b0;
			run_len_q   <= '0;
			first_q     <= 1'b1;
			bit_total_q <= '0;
		end else if (accept) begin
			if (fin) begin
				run_pixel_q <= 1'b0;
				run_len_q   <= '0;
				first_q     <= 1'b1;
				bit_total_q <= '0;
			end else begin
				run_pixel_q <= pix;
				run_len_q   <= run_len_d;
				first_q     <= 1'b0;
				bit_total_q <= total_d;
			end
		end
	end

	`BRLG_ASSERT_IMPL(a_open_run_nonzero, !first_q, run_len_q != '0, "open run has zero length")
	`BRLG_ASSERT_NEXT(a_final_clears, accept && fin, first_q && (bit_total_q == '0),
		"stream state not cleared after final pixel")
	`BRLG_ASSERT_IMPL(a_second_seg_final, push_valid && (push_cmd.len2 != '0), push_cmd.fin,
		"closing gamma code without final pixel")

endmodule

>>> rtl/brlg_fifo.sv
// Short command queue between the classifier and the bit packer.
module brlg_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  brlg_pkg::brlg_cmd_t push_cmd,
	output logic                pop_valid,
	input  logic                pop_ready,
	output brlg_pkg::brlg_cmd_t pop_cmd
);
	import brlg_pkg::*;

	brlg_cmd_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               push, pop;

	assign push_ready = (count_q != (FIFO_AW + 1)'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (FIFO_AW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (FIFO_AW + 1)'(1);
			end
		end
	end

endmodule

>>> rtl/brlg_back.sv
// Back end: packs command segments MSB first into bytes and drives the output register.
`include "bitplane_run_length_gamma_encoder_defines.svh"

module brlg_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	output logic                head_pop,
	input  brlg_pkg::brlg_cmd_t head_cmd,
	brlg_code_if.source         code_out
);
	import brlg_pkg::*;

	logic [ACC_W-1:0]   acc_q, base_acc, placed, acc_d;
	logic [FILL_W-1:0]  fill_q, base_fill, fill_d;
	logic               seg1_done_q, seg2_done_q;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  data_q;
	logic               bvalid_q, end_q;
	logic [TOTAL_W-1:0] bits_q;

	logic               pend1, pend2, slot_free, need_drain, drain, go, room;
	logic               ld1, ld2, more, last_byte, flush;
	logic [SEG_W-1:0]   ld_seg;
	logic [LEN_W-1:0]   ld_len;

	assign pend1      = head_valid && (head_cmd.len1 != '0) && !seg1_done_q;
	assign pend2      = head_valid && (head_cmd.len2 != '0) && !seg2_done_q;
	assign slot_free  = !out_valid_q || code_out.ready;
	assign need_drain = (fill_q >= FILL_W'(BYTE_W));
	assign drain      = head_valid && need_drain && slot_free;
	assign go         = !need_drain || drain;

	assign base_acc  = drain ? (acc_q << BYTE_W) : acc_q;
	assign base_fill = drain ? (fill_q - FILL_W'(BYTE_W)) : fill_q;
	assign room      = (base_fill < FILL_W'(BYTE_W));

	// At most one segment is appended per cycle, behind the bits still held.
	assign ld1    = go && pend1 && room;
	assign ld2    = go && pend2 && !pend1 && room;
	assign ld_seg = ld1 ? head_cmd.seg1 : head_cmd.seg2;
	assign ld_len = ld1 ? head_cmd.len1 : (ld2 ? head_cmd.len2 : '0);
	assign placed = (ld1 || ld2) ? ({ld_seg, {BYTE_W{1'b0}}} >> base_fill) : '0;
	assign acc_d  = base_acc | placed;
	assign fill_d = base_fill + FILL_W'(ld_len);
	assign more   = (pend1 && !ld1) || (pend2 && !ld2);

	// A full byte that empties the packer at the end of a stream closes it;
	// otherwise the end is closed by a padded or empty flush result.
	assign last_byte = drain && head_cmd.fin && !pend1 && !pend2 && (base_fill == '0);
	assign flush     = head_valid && head_cmd.fin && !need_drain && !pend1 && !pend2 && slot_free;

	always_comb begin
		if (head_cmd.fin) begin
			head_pop = last_byte || flush;
		end else begin
			head_pop = head_valid && go && !more && (fill_d < FILL_W'(BYTE_W));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			fill_q      <= '0;
			seg1_done_q <= 1'b0;
			seg2_done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (flush) begin
				acc_q  <= '0;
				fill_q <= '0;
			end else begin
				acc_q  <= acc_d;
				fill_q <= fill_d;
			end
			if (head_pop) begin
				seg1_done_q <= 1'b0;
				seg2_done_q <= 1'b0;
			end else begin
				seg1_done_q <= seg1_done_q || ld1;
				seg2_done_q <= seg2_done_q || ld2;
			end
			if (drain || flush) begin
				out_valid_q <= 1'b1;
			end else if (code_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			data_q   <= acc_q[ACC_W-1 -: BYTE_W];
			bvalid_q <= 1'b1;
			end_q    <= last_byte;
			bits_q   <= last_byte ? head_cmd.total : '0;
		end else if (flush) begin
			data_q   <= acc_q[ACC_W-1 -: BYTE_W];
			bvalid_q <= (fill_q != '0);
			end_q    <= 1'b1;
			bits_q   <= head_cmd.total;
		end
	end

	assign code_out.valid        = out_valid_q;
	assign code_out.data_byte    = data_q;
	assign code_out.byte_valid   = bvalid_q;
	assign code_out.stream_end   = end_q;
	assign code_out.encoded_bits = bits_q;

	`BRLG_ASSERT_IMPL(a_idle_under_byte, !head_valid, fill_q < FILL_W'(BYTE_W),
		"packer holds a full byte with no command")
	`BRLG_ASSERT_NEXT(a_end_empties, head_pop && head_cmd.fin,
		(fill_q == '0) && (acc_q == '0), "packer not empty after stream end")
	`BRLG_ASSERT_IMPL(a_blank_only_at_end, out_valid_q && !bvalid_q,
		end_q && (data_q == '0), "empty result outside stream end")

endmodule

>>> rtl/bitplane_run_length_gamma_encoder.sv
// Top level of the bit-plane run-length / gamma bit encoder.
// Usage:
// pix_in takes one pixel per transaction (valid and ready high at a clock edge);
// final_pixel marks the last pixel of an image. code_out delivers packed bytes,
// first coded bit in bit 7. The last result of an image has stream_end set and
// carries encoded_bits; in count-only mode it is the only result and byte_valid is 0.
// encode_mode is written through cfg_we/cfg_wdata while the encoder is idle; the user
// must keep to this, as the block itself does not enforce it.
// A result that needs no new bits packed, such as the count-only end result, passes
// through the queue and the output register; a byte completed by the pixel's own bits
// also passes through the packer accumulator between the two.
// Pixels are taken back to back while the queue has room. A pixel holds the packer
// while its segments are loaded and each byte its bits complete is drained; a final
// pixel with two code segments loads them one after the other, and the flush follows
// unless its last byte empties the packer. A four-entry queue absorbs bursts.
// A stall at code_out holds the output register; the queue keeps taking pixels until
// it is full, then pix_in.ready drops.
// Reset clears the run state, the packer and the queue and sets run-length mode.
module bitplane_run_length_gamma_encoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [brlg_pkg::MODE_W-1:0] cfg_wdata,
	brlg_pixel_if.sink                  pix_in,
	brlg_code_if.source                 code_out
);
	import brlg_pkg::*;

	logic      push_valid, push_ready;
	brlg_cmd_t push_cmd;
	logic      head_valid, head_pop;
	brlg_cmd_t head_cmd;

	brlg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.pix_in     (pix_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	brlg_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (head_valid),
		.pop_ready  (head_pop),
		.pop_cmd    (head_cmd)
	);

	brlg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.head_cmd   (head_cmd),
		.code_out   (code_out)
	);

endmodule

>>> tb/tb.sv
// Self-checking testbench for the bit-plane run-length / gamma bit encoder.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import brlg_pkg::*;

	localparam logic [MODE_W-1:0] MODE_COUNT     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_COUNT_ALT = 2'd3;
	localparam int MAX_CODES_PER_PIXEL = 6;
	localparam int DRAIN_CYCLES        = 16;
	localparam int LONG_HOLD           = 400;
	localparam int PHASE_PIXELS        = 60;

	typedef struct packed {
		logic pix;
		logic fin;
	} pixel_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  data_byte;
		logic               byte_valid;
		logic               stream_end;
		logic [TOTAL_W-1:0] encoded_bits;
	} code_item_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [MODE_W-1:0] cfg_wdata;

	brlg_pixel_if pix_if();
	brlg_code_if  code_if();

	bitplane_run_length_gamma_encoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.pix_in   (pix_if),
		.code_out (code_if)
	);

	pixel_item_t pixel_feed_q[$];
	code_item_t  expected_codes_q[$];
	pixel_item_t feed_item;
	code_item_t  want;

	int   idle_pct   = 0;
	int   stall_pct  = 0;
	int   err_count  = 0;
	logic pix_taken  = 1'b0;
	logic hold_req   = 1'b0;
	logic hold_ack   = 1'b0;
	int   hold_left  = 0;

	// Encoder state as the testbench sees it.
	logic [MODE_W-1:0]  enc_mode   = MODE_RLE;
	logic               run_px     = 1'b0;
	logic [RUN_W-1:0]   run_len    = '0;
	logic               first_px   = 1'b1;
	logic [BYTE_W-1:0]  pk_bits    = '0;
	int                 pk_fill    = 0;
	logic [TOTAL_W-1:0] bits_total = '0;
	logic [BYTE_W-1:0]  step_bytes[$];

	function automatic void clear_stream();
		run_px     = 1'b0;
		run_len    = '0;
		first_px   = 1'b1;
		pk_bits    = '0;
		pk_fill    = 0;
		bits_total = '0;
	endfunction

	function automatic void put_code_bit(input logic b, input logic pack);
		if (bits_total != TOTAL_MAX)
			bits_total = bits_total + 1'b1;
		if (!pack)
			return;
		pk_bits = {pk_bits[BYTE_W-2:0], b};
		pk_fill++;
		if (pk_fill == BYTE_W) begin
			if (step_bytes.size() < MAX_CODES_PER_PIXEL)
				step_bytes.push_back(pk_bits);
			pk_bits = '0;
			pk_fill = 0;
		end
	endfunction

	// Elias gamma: k-1 zeros, then the k significant bits of n, MSB first.
	function automatic void put_gamma(input logic [RUN_W-1:0] n, input logic pack);
		int k;
		k = 0;
		for (int i = 0; i < RUN_W; i++)
			if (n[i])
				k = i + 1;
		for (int i = 1; i < k; i++)
			put_code_bit(1'b0, pack);
		for (int i = k - 1; i >= 0; i--)
			put_code_bit(n[i], pack);
	endfunction

	function automatic void encode_pixel(input logic pix, input logic fin);
		logic              raw;
		logic              rle;
		logic              coded;
		logic [BYTE_W-1:0] tail;
		code_item_t        r;
		int                n;
		raw   = (enc_mode == MODE_RAW);
		rle   = (enc_mode == MODE_RLE);
		coded = !raw;
		step_bytes.delete();
		if (raw)
			put_code_bit(pix, 1'b1);
		if (first_px) begin
			if (coded)
				put_code_bit(pix, rle);
			run_px   = pix;
			run_len  = RUN_W'(1);
			first_px = 1'b0;
		end else if (pix == run_px) begin
			if (run_len != {RUN_W{1'b1}})
				run_len = run_len + 1'b1;
		end else begin
			if (coded)
				put_gamma(run_len, rle);
			run_px  = pix;
			run_len = RUN_W'(1);
		end
		if (fin) begin
			if (coded)
				put_gamma(run_len, rle);
			if (pk_fill > 0 && step_bytes.size() < MAX_CODES_PER_PIXEL) begin
				tail = pk_bits << (BYTE_W - pk_fill);
				step_bytes.push_back(tail);
			end
		end
		n = step_bytes.size();
		for (int k = 0; k < n; k++) begin
			r.data_byte    = step_bytes[k];
			r.byte_valid   = 1'b1;
			r.stream_end   = fin && (k == n - 1);
			r.encoded_bits = r.stream_end ? bits_total : '0;
			expected_codes_q.push_back(r);
		end
		if (fin && n == 0) begin
			r.data_byte    = '0;
			r.byte_valid   = 1'b0;
			r.stream_end   = 1'b1;
			r.encoded_bits = bits_total;
			expected_codes_q.push_back(r);
		end
		if (fin)
			clear_stream();
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[bitplane_run_length_gamma_encoder] ERROR");
		$finish;
	end

	// Pixel driver: a new transaction is offered once the previous one was taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			pix_if.valid       <= 1'b0;
			pix_if.pixel_value <= 1'b0;
			pix_if.final_pixel <= 1'b0;
		end else if (!pix_if.valid || pix_taken) begin
			if (pixel_feed_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				feed_item = pixel_feed_q.pop_front();
				pix_if.valid       <= 1'b1;
				pix_if.pixel_value <= feed_item.pix;
				pix_if.final_pixel <= feed_item.fin;
			end else begin
				pix_if.valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, started by a toggle of hold_req.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_left <= LONG_HOLD;
			hold_ack  <= hold_req;
		end
	end

	always @(negedge clk) begin
		code_if.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		pix_taken <= pix_if.valid && pix_if.ready;
		if (arst_n && code_if.valid && code_if.ready) begin
			if (expected_codes_q.size() == 0) begin
				$error("unexpected result: data_byte %0h byte_valid %0b stream_end %0b",
					code_if.data_byte, code_if.byte_valid, code_if.stream_end);
				err_count++;
			end else begin
				want = expected_codes_q.pop_front();
				if (code_if.data_byte !== want.data_byte) begin
					$error("data_byte: expected %0h, got %0h", want.data_byte,
						code_if.data_byte);
					err_count++;
				end
				if (code_if.byte_valid !== want.byte_valid) begin
					$error("byte_valid: expected %0b, got %0b", want.byte_valid,
						code_if.byte_valid);
					err_count++;
				end
				if (code_if.stream_end !== want.stream_end) begin
					$error("stream_end: expected %0b, got %0b", want.stream_end,
						code_if.stream_end);
					err_count++;
				end
				if (code_if.encoded_bits !== want.encoded_bits) begin
					$error("encoded_bits: expected %0d, got %0d", want.encoded_bits,
						code_if.encoded_bits);
					err_count++;
				end
			end
		end
		if (arst_n && pix_if.valid && pix_if.ready)
			encode_pixel(pix_if.pixel_value, pix_if.final_pixel);
	end

	task automatic push_run(input logic v, input int len, input logic close);
		pixel_item_t it;
		for (int i = 0; i < len; i++) begin
			it.pix = v;
			it.fin = close && (i == len - 1);
			pixel_feed_q.push_back(it);
		end
	endtask

	task automatic push_random(input int len);
		pixel_item_t it;
		for (int i = 0; i < len; i++) begin
			it.pix = 1'($urandom_range(1));
			it.fin = (i == len - 1);
			pixel_feed_q.push_back(it);
		end
	endtask

	// Waits until every pixel is taken and every result is in, then lets the block settle.
	task automatic drain_encoder();
		while (pixel_feed_q.size() != 0 || pix_if.valid || expected_codes_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] m);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we   <= 1'b0;
		enc_mode = m;
		@(posedge clk);
	endtask

	initial begin
		int   done_px;
		int   runs;
		int   len;
		logic v;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed: single-pixel streams, a few runs, every mode.
		write_mode(MODE_RLE);
		push_run(1'b1, 1, 1'b1);
		push_run(1'b0, 1, 1'b1);
		push_run(1'b1, 3, 1'b0);
		push_run(1'b0, 2, 1'b0);
		push_run(1'b1, 1, 1'b1);
		drain_encoder();
		write_mode(MODE_RAW);
		for (int i = 0; i < 8; i++)
			push_run(i[0], 1, i == 7);
		drain_encoder();
		write_mode(MODE_COUNT);
		push_run(1'b0, 2, 1'b0);
		push_run(1'b1, 1, 1'b1);
		drain_encoder();
		write_mode(MODE_COUNT_ALT);
		push_run(1'b1, 2, 1'b1);
		drain_encoder();

		// Mode changed in the middle of one stream; packed bits carry over.
		write_mode(MODE_RLE);
		push_run(1'b1, 2, 1'b0);
		push_run(1'b0, 1, 1'b0);
		drain_encoder();
		write_mode(MODE_RAW);
		push_run(1'b1, 1, 1'b0);
		push_run(1'b0, 1, 1'b0);
		push_run(1'b1, 1, 1'b0);
		drain_encoder();
		write_mode(MODE_COUNT);
		push_run(1'b0, 2, 1'b1);
		drain_encoder();

		// Random streams under four idling patterns.
		for (int phase = 0; phase < 4; phase++) begin
			drain_encoder();
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 59; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 59; end
				default: begin idle_pct = 30; stall_pct = 30; end
			endcase
			if (phase == 0) begin
				// Receiver holds off while pixels keep coming, so the input backs up.
				write_mode(MODE_RAW);
				hold_req = ~hold_req;
				push_random(60);
				drain_encoder();
			end
			done_px = 0;
			while (done_px < PHASE_PIXELS) begin
				if ($urandom_range(2) == 0) begin
					drain_encoder();
					write_mode(MODE_W'($urandom_range(3)));
				end
				runs = int'($urandom_range(1, 8));
				v = 1'($urandom_range(1));
				for (int r = 0; r < runs; r++) begin
					if (r > 0 && $urandom_range(7) == 0) begin
						drain_encoder();
						write_mode(MODE_W'($urandom_range(3)));
					end
					len = ($urandom_range(19) == 0) ? int'($urandom_range(1, 200))
						: int'($urandom_range(1, 4));
					push_run(v, len, r == runs - 1);
					done_px += len;
					if ($urandom_range(3) != 0)
						v = ~v;
				end
			end
		end

		drain_encoder();

		if (err_count == 0) begin
			$display("[bitplane_run_length_gamma_encoder] OK");
		end else begin
			$display("[bitplane_run_length_gamma_encoder] ERROR");
		end
		$finish;
	end
endmodule
